// ===== design/spectral_norm_power_iteration_assert.svh =====
// Assertion macros shared by the spectral norm RTL.
`ifndef SPECTRAL_NORM_POWER_ITERATION_ASSERT_SVH
`define SPECTRAL_NORM_POWER_ITERATION_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define SNPI_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define SNPI_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/snpi_pkg.sv =====
// Shared types, codes and helpers of the spectral norm estimator.
package snpi_pkg;

	localparam int MAX_ROWS   = 16;
	localparam int MAX_COLS   = 16;
	localparam int DIV_STEPS  = 48;
	localparam int SQRT_STEPS = 32;

	// Command codes carried in tuser
	localparam logic [2:0] FN_LOAD_W = 3'd0;
	localparam logic [2:0] FN_LOAD_U = 3'd1;
	localparam logic [2:0] FN_LOAD_V = 3'd2;
	localparam logic [2:0] FN_RUN    = 3'd3;
	localparam logic [2:0] FN_READ_W = 3'd4;
	localparam logic [2:0] FN_READ_V = 3'd5;

	// Result kinds
	localparam logic [1:0] KIND_SIGMA = 2'd0;
	localparam logic [1:0] KIND_W     = 2'd1;
	localparam logic [1:0] KIND_U     = 2'd2;
	localparam logic [1:0] KIND_V     = 2'd3;

	// Configuration register indexes
	localparam logic [1:0] CFG_ROWS = 2'd0;
	localparam logic [1:0] CFG_COLS = 2'd1;
	localparam logic [1:0] CFG_ITER = 2'd2;
	localparam logic [1:0] CFG_EPS  = 2'd3;

	// Vector memory banks: upper address bits
	localparam logic [1:0] VS_U  = 2'd0;
	localparam logic [1:0] VS_V  = 2'd1;
	localparam logic [1:0] VS_TU = 2'd2;
	localparam logic [1:0] VS_TV = 2'd3;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MAC,
		ST_DRAIN,
		ST_SQRT,
		ST_DRD,
		ST_DST,
		ST_DWT,
		ST_WST,
		ST_WWT,
		ST_VRD,
		ST_OUT
	} st_t;

	typedef enum logic [2:0] {
		P_WTU,
		P_NV,
		P_WV,
		P_NU,
		P_WVF,
		P_DOT
	} pass_t;

	typedef struct packed {
		logic       vld;
		logic       first;
		logic       last;
		logic       sq;
		logic [5:0] dst;
	} mac_tag_t;

	typedef struct packed {
		logic       vld;
		logic       busy;
		logic [5:0] dst;
	} mac_res_t;

	// Q32.32 to Q16.16: floor shift, then clamp to 32-bit signed.
	function automatic logic signed [31:0] sat_q16(input logic signed [63:0] acc);
		logic signed [47:0] sh;
		sh = acc[63:16];
		if (sh > 48'sh0000_7FFF_FFFF)
			return 32'sh7FFF_FFFF;
		if (sh < 48'shFFFF_8000_0000)
			return 32'sh8000_0000;
		return sh[31:0];
	endfunction

endpackage

// ===== design/snpi_wram.sv =====
// Weight memory: one write port, one registered read port.
module snpi_wram (
	input  logic        clk,
	input  logic        we,
	input  logic [7:0]  waddr,
	input  logic [31:0] wdata,
	input  logic [7:0]  raddr,
	output logic [31:0] rdata
);
	logic [31:0] mem [256];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

// ===== design/snpi_vram.sv =====
// Vector memory for u, v and their scratch copies, two read ports.
module snpi_vram (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        we,
	input  logic [5:0]  waddr,
	input  logic [31:0] wdata,
	input  logic [5:0]  ra_addr,
	input  logic [5:0]  rb_addr,
	output logic [31:0] ra_data,
	output logic [31:0] rb_data
);
	logic [31:0] mem [64];
	logic [63:0] vld_q;
	logic [31:0] ra_q, rb_q;
	logic        ra_v_q, rb_v_q;

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		ra_q <= mem[ra_addr];
		rb_q <= mem[rb_addr];
	end

	// Entries never written read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			ra_v_q <= 1'b0;
			rb_v_q <= 1'b0;
		end else begin
			if (we)
				vld_q[waddr] <= 1'b1;
			ra_v_q <= vld_q[ra_addr];
			rb_v_q <= vld_q[rb_addr];
		end
	end

	assign ra_data = ra_v_q ? ra_q : '0;
	assign rb_data = rb_v_q ? rb_q : '0;
endmodule

// ===== design/snpi_mac.sv =====
// Multiply-accumulate pipeline: signed saturating dot or unsigned sum of squares.
module snpi_mac (
	input  logic                clk,
	input  logic                arst_n,
	input  snpi_pkg::mac_tag_t  tag,
	input  logic signed [31:0]  op_a,
	input  logic signed [31:0]  op_b,
	output snpi_pkg::mac_res_t  res,
	output logic signed [63:0]  acc
);
	import snpi_pkg::*;

	mac_tag_t           tag_s1, tag_s2;
	logic signed [63:0] prod_s2;
	logic signed [63:0] acc_q, acc_d, base;
	logic [64:0]        usum;
	logic signed [64:0] ssum;
	logic               res_vld_q;
	logic [5:0]         res_dst_q;

	always_comb begin
		base = tag_s2.first ? 64'sd0 : acc_q;
		usum = {1'b0, base} + {1'b0, prod_s2};
		ssum = {base[63], base} + {prod_s2[63], prod_s2};
		if (tag_s2.sq)
			acc_d = usum[64] ? '1 : usum[63:0];
		else if (ssum[64] != ssum[63])
			acc_d = ssum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
		else
			acc_d = ssum[63:0];
	end

	always_ff @(posedge clk) begin
		prod_s2 <= op_a * op_b;
		if (tag_s2.vld)
			acc_q <= acc_d;
		res_dst_q <= tag_s2.dst;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1    <= '0;
			tag_s2    <= '0;
			res_vld_q <= 1'b0;
		end else begin
			tag_s1    <= tag;
			tag_s2    <= tag_s1;
			res_vld_q <= tag_s2.vld & tag_s2.last;
		end
	end

	assign res.vld  = res_vld_q;
	assign res.busy = tag_s1.vld | tag_s2.vld | res_vld_q;
	assign res.dst  = res_dst_q;
	assign acc      = acc_q;
endmodule

// ===== design/snpi_sqrt.sv =====
// Floor square root of a 64-bit value, two radicand bits per cycle.
module snpi_sqrt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] x,
	output logic [31:0] root,
	output logic        done,
	output logic        busy
);
	import snpi_pkg::*;

	logic [63:0] rad_q;
	logic [33:0] rem_q;
	logic [31:0] root_q;
	logic [4:0]  cnt_q;
	logic        run_q, done_q;
	logic [35:0] rem_sh, trial, rem_n;
	logic        ge;

	always_comb begin
		rem_sh = {rem_q, rad_q[63:62]};
		trial  = {2'b00, root_q, 2'b01};
		ge     = rem_sh >= trial;
		rem_n  = ge ? rem_sh - trial : rem_sh;
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= x;
			rem_q  <= '0;
			root_q <= '0;
		end else if (run_q) begin
			rad_q  <= {rad_q[61:0], 2'b00};
			rem_q  <= rem_n[33:0];
			root_q <= {root_q[30:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= '0;
				run_q <= 1'b1;
			end else if (run_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'(SQRT_STEPS - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Clamp to the signed Q16.16 maximum
	assign root = root_q[31] ? 32'h7FFF_FFFF : root_q;
	assign done = done_q;
	assign busy = run_q;
endmodule

// ===== design/snpi_div.sv =====
// Restoring divider: signed 48-bit numerator by a positive 32-bit divisor, saturated.
module snpi_div (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [47:0] num,
	input  logic [31:0]        den,
	output logic signed [31:0] quo,
	output logic               done,
	output logic               busy
);
	import snpi_pkg::*;

	logic [47:0]        q_q, mag, qf;
	logic [31:0]        rem_q, den_q;
	logic [5:0]         cnt_q;
	logic               run_q, done_q, neg_q;
	logic signed [31:0] quo_q;
	logic [32:0]        rem_sh, rem_n;
	logic               ge;

	always_comb begin
		mag    = num[47] ? 48'(-num) : num;
		rem_sh = {rem_q, q_q[47]};
		ge     = rem_sh >= {1'b0, den_q};
		rem_n  = ge ? rem_sh - {1'b0, den_q} : rem_sh;
		qf     = {q_q[46:0], ge};
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q   <= mag;
			rem_q <= '0;
			den_q <= den;
			neg_q <= num[47];
		end else if (run_q) begin
			q_q   <= qf;
			rem_q <= rem_n[31:0];
			if (cnt_q == 6'(DIV_STEPS - 1)) begin
				if (neg_q)
					quo_q <= (qf > 48'h0000_8000_0000) ? 32'sh8000_0000 : -qf[31:0];
				else
					quo_q <= (qf > 48'h0000_7FFF_FFFF) ? 32'sh7FFF_FFFF : qf[31:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= '0;
				run_q <= 1'b1;
			end else if (run_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'(DIV_STEPS - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign quo  = quo_q;
	assign done = done_q;
	assign busy = run_q;
endmodule

// ===== design/spectral_norm_power_iteration.sv =====
// Loads are written when accepted at the input; a read holds the input until its result is in the output reg.
// A u/v read is taken from the vector memory, a scaled weight read from the 48-step divider,
// and a run makes the MAC passes over the weight memory, the 32-step square root and the
// one-bit-per-cycle divider; a normalization whose norm is within eps skips its divisions.
// One result can wait.
// Reset returns control and config to defaults; u and v read as zero, sigma is 1.0, weights undefined.
`include "spectral_norm_power_iteration_assert.svh"
module spectral_norm_power_iteration (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// row_index[3:0], col_index[7:4], read_vector_v[8], load_value[40:9], zero pad
	input  logic [47:0] s_axis_tdata,
	// func[2:0]
	input  logic [2:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// result_value[31:0]
	output logic [31:0] m_axis_tdata,
	// result_kind[1:0]
	output logic [1:0]  m_axis_tuser,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [16:0] cfg_wdata
);
	import snpi_pkg::*;

	st_t   state_q, state_d;
	pass_t pass_q, nrm_pass;

	logic [4:0]  row_q, col_q, n_rows, n_cols, n_in, n_out, n_div;
	logic [7:0]  iter_q, it_q, nrm_it;
	logic [16:0] eps_q, eps_v;
	logic [3:0]  i_q, o_q;
	logic        last_in, last_out, last_div;

	logic signed [31:0] sigma_q, sig_den, pend_val_q, out_val_q;
	logic [1:0]         pend_kind_q, out_kind_q;
	logic               out_vld_q, out_free;

	logic        accept;
	logic [3:0]  in_row, in_col;
	logic        in_rvv;
	logic [31:0] in_val;

	logic        wr_we;
	logic [7:0]  wr_waddr, wr_raddr;
	logic [31:0] wr_rdata;

	logic        ld_we, mac_we, dv_we, vr_we;
	logic [5:0]  vr_waddr, va_addr, vb_addr;
	logic [31:0] vr_wdata, va_data, vb_data;

	mac_tag_t           tag;
	mac_res_t           mres;
	logic signed [31:0] op_a, op_b;
	logic signed [63:0] macc;

	logic               sq_start, sq_done, sq_busy;
	logic [31:0]        root;
	logic               nrm_ok;
	logic               div_start, div_done, div_busy;
	logic signed [47:0] div_num;
	logic [31:0]        div_den;
	logic signed [31:0] quo;

	assign in_row = s_axis_tdata[3:0];
	assign in_col = s_axis_tdata[7:4];
	assign in_rvv = s_axis_tdata[8];
	assign in_val = s_axis_tdata[40:9];

	assign s_axis_tready = (state_q == ST_IDLE);
	assign accept        = s_axis_tvalid & s_axis_tready;
	assign out_free      = !out_vld_q || m_axis_tready;

	// Clamp counts into 1..max and eps to at least one LSB
	always_comb begin
		n_rows = (row_q == 5'd0) ? 5'd1 : ((row_q > 5'(MAX_ROWS)) ? 5'(MAX_ROWS) : row_q);
		n_cols = (col_q == 5'd0) ? 5'd1 : ((col_q > 5'(MAX_COLS)) ? 5'(MAX_COLS) : col_q);
		eps_v  = (eps_q == 17'd0) ? 17'd1 : eps_q;
		sig_den = (sigma_q > $signed({15'd0, eps_v})) ? sigma_q : $signed({15'd0, eps_v});
		nrm_ok = root > {15'd0, eps_v};
	end

	always_comb begin
		case (pass_q)
			P_WTU: begin
				n_in  = n_rows;
				n_out = n_cols;
			end
			P_WV, P_WVF: begin
				n_in  = n_cols;
				n_out = n_rows;
			end
			P_NV: begin
				n_in  = n_cols;
				n_out = 5'd1;
			end
			default: begin
				n_in  = n_rows;
				n_out = 5'd1;
			end
		endcase
		n_div    = (pass_q == P_NV) ? n_cols : n_rows;
		last_in  = {1'b0, i_q} == n_in - 5'd1;
		last_out = {1'b0, o_q} == n_out - 5'd1;
		last_div = {1'b0, i_q} == n_div - 5'd1;
	end

	// Pass that follows a finished normalization of v or u
	always_comb begin
		nrm_it = it_q;
		if (pass_q == P_NV)
			nrm_pass = P_WV;
		else if (it_q <= 8'd1)
			nrm_pass = P_WVF;
		else begin
			nrm_pass = P_WTU;
			nrm_it   = it_q - 8'd1;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (s_axis_tuser)
						FN_RUN:    state_d = ST_MAC;
						FN_READ_W: state_d = ST_WST;
						FN_READ_V: state_d = ST_VRD;
						default:   state_d = ST_IDLE;
					endcase
				end
			end
			ST_MAC: begin
				if (last_in && last_out)
					state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (!mres.busy) begin
					case (pass_q)
						P_NV, P_NU: state_d = ST_SQRT;
						P_DOT:      state_d = ST_OUT;
						default:    state_d = ST_MAC;
					endcase
				end
			end
			ST_SQRT: begin
				if (sq_done)
					state_d = nrm_ok ? ST_DRD : ST_MAC;
			end
			ST_DRD: state_d = ST_DST;
			ST_DST: state_d = ST_DWT;
			ST_DWT: begin
				if (div_done)
					state_d = last_div ? ST_MAC : ST_DRD;
			end
			ST_WST: state_d = ST_WWT;
			ST_WWT: begin
				if (div_done)
					state_d = ST_OUT;
			end
			ST_VRD: state_d = ST_OUT;
			ST_OUT: begin
				if (out_free)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Memory addresses, unit starts and write strobes
	always_comb begin
		wr_we     = 1'b0;
		wr_waddr  = {in_row, in_col};
		wr_raddr  = {in_row, in_col};
		ld_we     = 1'b0;
		dv_we     = 1'b0;
		vr_waddr  = {VS_U, in_row};
		vr_wdata  = in_val;
		va_addr   = {VS_U, i_q};
		vb_addr   = {VS_TU, i_q};
		tag       = '0;
		sq_start  = 1'b0;
		div_start = 1'b0;
		div_num   = {wr_rdata, 16'd0};
		div_den   = sig_den;
		case (state_q)
			ST_IDLE: begin
				va_addr = in_rvv ? {VS_V, in_col} : {VS_U, in_row};
				if (accept) begin
					case (s_axis_tuser)
						FN_LOAD_W: wr_we = 1'b1;
						FN_LOAD_U: ld_we = 1'b1;
						FN_LOAD_V: begin
							ld_we    = 1'b1;
							vr_waddr = {VS_V, in_col};
						end
						default: ld_we = 1'b0;
					endcase
				end
			end
			ST_MAC: begin
				tag.vld   = 1'b1;
				tag.first = (i_q == 4'd0);
				tag.last  = last_in;
				tag.sq    = (pass_q == P_NV) || (pass_q == P_NU);
				case (pass_q)
					P_WTU: begin
						wr_raddr = {i_q, o_q};
						va_addr  = {VS_U, i_q};
						tag.dst  = {VS_TV, o_q};
					end
					P_WV, P_WVF: begin
						wr_raddr = {o_q, i_q};
						va_addr  = {VS_V, i_q};
						tag.dst  = {VS_TU, o_q};
					end
					P_NV:    va_addr = {VS_TV, i_q};
					default: va_addr = {VS_U, i_q};
				endcase
				if (pass_q == P_NU)
					va_addr = {VS_TU, i_q};
			end
			ST_DRAIN: begin
				sq_start = !mres.busy && ((pass_q == P_NV) || (pass_q == P_NU));
			end
			ST_DRD: va_addr = {(pass_q == P_NV) ? VS_TV : VS_TU, i_q};
			ST_DST: begin
				div_start = 1'b1;
				div_num   = {va_data, 16'd0};
				div_den   = root;
			end
			ST_DWT: begin
				dv_we    = div_done;
				vr_waddr = {(pass_q == P_NV) ? VS_V : VS_U, i_q};
				vr_wdata = quo;
			end
			ST_WST: div_start = 1'b1;
			default: tag = '0;
		endcase
		mac_we = mres.vld && ((pass_q == P_WTU) || (pass_q == P_WV) || (pass_q == P_WVF));
		if (mac_we) begin
			vr_waddr = mres.dst;
			vr_wdata = sat_q16(macc);
		end
		vr_we = ld_we | mac_we | dv_we;
	end

	assign op_a = ((pass_q == P_WTU) || (pass_q == P_WV) || (pass_q == P_WVF)) ?
		wr_rdata : va_data;
	assign op_b = (pass_q == P_DOT) ? vb_data : va_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pass_q      <= P_WTU;
			i_q         <= '0;
			o_q         <= '0;
			it_q        <= '0;
			row_q       <= 5'd16;
			col_q       <= 5'd16;
			iter_q      <= 8'd1;
			eps_q       <= 17'd1;
			sigma_q     <= 32'sd65536;
			pend_kind_q <= KIND_SIGMA;
			out_vld_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (cfg_index)
					CFG_ROWS: row_q  <= cfg_wdata[4:0];
					CFG_COLS: col_q  <= cfg_wdata[4:0];
					CFG_ITER: iter_q <= cfg_wdata[7:0];
					CFG_EPS:  eps_q  <= cfg_wdata;
					default:  eps_q  <= eps_q;
				endcase
			end
			if (mres.vld && (pass_q == P_DOT))
				sigma_q <= sat_q16(macc);
			case (state_q)
				ST_IDLE: begin
					i_q <= '0;
					o_q <= '0;
					if (accept && (s_axis_tuser == FN_RUN)) begin
						it_q   <= iter_q;
						pass_q <= (iter_q == 8'd0) ? P_WVF : P_WTU;
					end
					if (accept && (s_axis_tuser == FN_READ_V))
						pend_kind_q <= in_rvv ? KIND_V : KIND_U;
				end
				ST_MAC: begin
					if (last_in) begin
						i_q <= '0;
						o_q <= o_q + 4'd1;
					end else
						i_q <= i_q + 4'd1;
				end
				ST_DRAIN: begin
					i_q <= '0;
					o_q <= '0;
					if (!mres.busy) begin
						case (pass_q)
							P_WTU:   pass_q <= P_NV;
							P_WV:    pass_q <= P_NU;
							P_WVF:   pass_q <= P_DOT;
							P_DOT:   pend_kind_q <= KIND_SIGMA;
							default: pass_q <= pass_q;
						endcase
					end
				end
				ST_SQRT: begin
					i_q <= '0;
					o_q <= '0;
					if (sq_done && !nrm_ok) begin
						pass_q <= nrm_pass;
						it_q   <= nrm_it;
					end
				end
				ST_DWT: begin
					if (div_done) begin
						if (last_div) begin
							i_q    <= '0;
							pass_q <= nrm_pass;
							it_q   <= nrm_it;
						end else
							i_q <= i_q + 4'd1;
					end
				end
				ST_WWT: pend_kind_q <= KIND_W;
				default: i_q <= i_q;
			endcase
			if (state_q == ST_OUT && out_free)
				out_vld_q <= 1'b1;
			else if (m_axis_tready)
				out_vld_q <= 1'b0;
		end
	end

	// Result payload, held until the output register takes it
	always_ff @(posedge clk) begin
		if (state_q == ST_DRAIN && pass_q == P_DOT)
			pend_val_q <= sigma_q;
		if (state_q == ST_WWT && div_done)
			pend_val_q <= quo;
		if (state_q == ST_VRD)
			pend_val_q <= va_data;
		if (state_q == ST_OUT && out_free) begin
			out_val_q  <= pend_val_q;
			out_kind_q <= pend_kind_q;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = out_val_q;
	assign m_axis_tuser  = out_kind_q;

	snpi_wram u_wram (
		.clk   (clk),
		.we    (wr_we),
		.waddr (wr_waddr),
		.wdata (in_val),
		.raddr (wr_raddr),
		.rdata (wr_rdata)
	);

	snpi_vram u_vram (
		.clk     (clk),
		.arst_n  (arst_n),
		.we      (vr_we),
		.waddr   (vr_waddr),
		.wdata   (vr_wdata),
		.ra_addr (va_addr),
		.rb_addr (vb_addr),
		.ra_data (va_data),
		.rb_data (vb_data)
	);

	snpi_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.tag    (tag),
		.op_a   (op_a),
		.op_b   (op_b),
		.res    (mres),
		.acc    (macc)
	);

	snpi_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sq_start),
		.x      (macc),
		.root   (root),
		.done   (sq_done),
		.busy   (sq_busy)
	);

	snpi_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.quo    (quo),
		.done   (div_done),
		.busy   (div_busy)
	);

	`SNPI_ASSERT_IMP(a_div_idle, div_start, !div_busy, "divider restarted while busy")
	`SNPI_ASSERT_IMP(a_sqrt_idle, sq_start, !sq_busy, "square root restarted while busy")
	`SNPI_ASSERT_IMP(a_vram_one_writer, 1'b1, $onehot0({ld_we, mac_we, dv_we}),
		"vector memory written by two sources")
	`SNPI_ASSERT_IMP(a_mac_in_pass, mres.vld, (state_q == ST_MAC) || (state_q == ST_DRAIN),
		"accumulator result outside a pass")
	`SNPI_ASSERT_NXT(a_out_load, (state_q == ST_OUT) && out_free, m_axis_tvalid,
		"pending result not moved to output")
endmodule

// ===== bench/tb_spectral_norm_power_iteration.sv =====
// Testbench for the spectral norm power iteration block: random and directed items, scoreboard.
`timescale 1ns / 1ps
module tb_spectral_norm_power_iteration;
	import snpi_pkg::*;

	localparam longint CYCLE_LIMIT = 4000000;
	localparam longint HI32 = 64'sh0000_0000_7FFF_FFFF;
	localparam longint LO32 = -64'sh0000_0000_8000_0000;

	typedef struct {
		logic [2:0]  fn;
		logic [3:0]  row;
		logic [3:0]  col;
		logic        rvv;
		logic [31:0] val;
	} cmd_t;

	typedef struct {
		logic [31:0] value;
		logic [1:0]  kind;
	} answer_t;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        s_axis_tvalid = 0;
	logic        s_axis_tready;
	logic [47:0] s_axis_tdata = '0;
	logic [2:0]  s_axis_tuser = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 0;
	logic [31:0] m_axis_tdata;
	logic [1:0]  m_axis_tuser;
	logic        cfg_we = 0;
	logic [1:0]  cfg_index = '0;
	logic [16:0] cfg_wdata = '0;

	cmd_t    pending_cmds[$];
	answer_t expected_answers[$];
	cmd_t    cur_cmd;
	int      mismatches = 0;
	longint  cyc = 0;
	int      hold_left = 0;
	bit      hold_done = 0;

	// predictor state
	longint     w_mem[16][16];
	longint     u_vec[16];
	longint     v_vec[16];
	longint     fresh[16];
	longint     sigma_q;
	logic [4:0]  rows_reg;
	logic [4:0]  cols_reg;
	logic [7:0]  iter_reg;
	logic [16:0] eps_reg;

	// stimulus bookkeeping
	bit gen_written[16][16];
	int gen_rows;
	int gen_cols;

	spectral_norm_power_iteration dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic longint sat32(longint x);
		if (x > HI32)
			return HI32;
		if (x < LO32)
			return LO32;
		return x;
	endfunction

	function automatic longint acc_add(longint a, longint b);
		longint r;
		r = a + b;
		if (b > 0 && r < a)
			return 64'sh7FFF_FFFF_FFFF_FFFF;
		if (b < 0 && r > a)
			return 64'sh8000_0000_0000_0000;
		return r;
	endfunction

	function automatic longint unsigned isqrt(longint unsigned x);
		longint unsigned r, b;
		r = 0;
		b = 64'h4000_0000_0000_0000;
		while (b > x)
			b = b >> 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x = x - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic longint eps_eff();
		return (eps_reg == 0) ? 1 : longint'(eps_reg);
	endfunction

	function automatic int clamp_count(logic [4:0] n);
		if (n == 0)
			return 1;
		return (n > 16) ? 16 : int'(n);
	endfunction

	// Replace u or v by fresh / |fresh| unless the norm is within eps.
	function automatic void normalize_fresh(bit to_v, int n);
		longint unsigned acc, a, sq;
		longint nrm;
		acc = 0;
		for (int i = 0; i < n; i++) begin
			a = (fresh[i] < 0) ? longint'(-fresh[i]) : fresh[i];
			sq = a * a;
			acc = (acc > 64'hFFFF_FFFF_FFFF_FFFF - sq) ? 64'hFFFF_FFFF_FFFF_FFFF : acc + sq;
		end
		acc = isqrt(acc);
		nrm = (acc > 64'h7FFF_FFFF) ? HI32 : longint'(acc);
		if (nrm <= eps_eff())
			return;
		for (int i = 0; i < n; i++) begin
			if (to_v)
				v_vec[i] = sat32((fresh[i] * 65536) / nrm);
			else
				u_vec[i] = sat32((fresh[i] * 65536) / nrm);
		end
	endfunction

	function automatic void w_times_v(int nr, int nc);
		longint acc;
		for (int r = 0; r < nr; r++) begin
			acc = 0;
			for (int c = 0; c < nc; c++)
				acc = acc_add(acc, w_mem[r][c] * v_vec[c]);
			fresh[r] = sat32(acc >>> 16);
		end
	endfunction

	function automatic longint power_iterate();
		int nr, nc;
		longint acc;
		nr = clamp_count(rows_reg);
		nc = clamp_count(cols_reg);
		for (int it = 0; it < int'(iter_reg); it++) begin
			for (int c = 0; c < nc; c++) begin
				acc = 0;
				for (int r = 0; r < nr; r++)
					acc = acc_add(acc, w_mem[r][c] * u_vec[r]);
				fresh[c] = sat32(acc >>> 16);
			end
			normalize_fresh(1, nc);
			w_times_v(nr, nc);
			normalize_fresh(0, nr);
		end
		w_times_v(nr, nc);
		acc = 0;
		for (int r = 0; r < nr; r++)
			acc = acc_add(acc, u_vec[r] * fresh[r]);
		sigma_q = sat32(acc >>> 16);
		return sigma_q;
	endfunction

	function automatic void predict_item(cmd_t cmd);
		longint val, s;
		answer_t ans;
		val = longint'(signed'(cmd.val));
		case (cmd.fn)
			FN_LOAD_W: w_mem[cmd.row][cmd.col] = val;
			FN_LOAD_U: u_vec[cmd.row] = val;
			FN_LOAD_V: v_vec[cmd.col] = val;
			FN_RUN: begin
				ans.value = 32'(power_iterate());
				ans.kind = KIND_SIGMA;
				expected_answers.push_back(ans);
			end
			FN_READ_W: begin
				s = (sigma_q > eps_eff()) ? sigma_q : eps_eff();
				ans.value = 32'(sat32((w_mem[cmd.row][cmd.col] * 65536) / s));
				ans.kind = KIND_W;
				expected_answers.push_back(ans);
			end
			FN_READ_V: begin
				ans.value = cmd.rvv ? 32'(v_vec[cmd.col]) : 32'(u_vec[cmd.row]);
				ans.kind = cmd.rvv ? KIND_V : KIND_U;
				expected_answers.push_back(ans);
			end
			default: ;
		endcase
	endfunction

	task automatic report_mismatch(string msg);
		mismatches++;
		$display("mismatch at cycle %0d: %s", cyc, msg);
	endtask

	// cycle count and watchdog
	always @(posedge clk) begin
		cyc <= cyc + 1;
		if (cyc > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cyc);
			$display("TB_ERROR");
			$finish;
		end
	end

	function automatic bit calm_window();
		return cyc >= 20000 && cyc < 32000;
	endfunction

	// input driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				predict_item(cur_cmd);
			if (!s_axis_tvalid || s_axis_tready) begin
				if (pending_cmds.size() > 0 && (calm_window() || $urandom_range(0, 99) >= 18)) begin
					cur_cmd = pending_cmds.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= {7'b0, cur_cmd.val, cur_cmd.rvv, cur_cmd.col, cur_cmd.row};
					s_axis_tuser <= cur_cmd.fn;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// output monitor and receiver stalls
	always @(posedge clk) begin
		answer_t ans;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_answers.size() == 0) begin
					report_mismatch($sformatf("unexpected result %h kind %0d",
						m_axis_tdata, m_axis_tuser));
				end else begin
					ans = expected_answers.pop_front();
					if (m_axis_tdata !== ans.value)
						report_mismatch($sformatf("value %h, want %h", m_axis_tdata, ans.value));
					if (m_axis_tuser !== ans.kind)
						report_mismatch($sformatf("kind %0d, want %0d", m_axis_tuser, ans.kind));
				end
			end
			// hold off the output for a long stretch once so the input backs up
			if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				m_axis_tready <= 1'b0;
			end else if (!hold_done && cyc >= 5000 && pending_cmds.size() > 10) begin
				hold_done <= 1'b1;
				hold_left <= 4000;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= calm_window() || $urandom_range(0, 99) >= 18;
			end
		end
	end

	task automatic push_cmd(logic [2:0] fn, logic [3:0] row, logic [3:0] col, logic rvv,
			logic [31:0] val);
		cmd_t cmd;
		cmd.fn = fn;
		cmd.row = row;
		cmd.col = col;
		cmd.rvv = rvv;
		cmd.val = val;
		pending_cmds.push_back(cmd);
		if (fn == FN_LOAD_W)
			gen_written[row][col] = 1;
	endtask

	task automatic cfg_write(logic [1:0] idx, logic [16:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		case (idx)
			CFG_ROWS: rows_reg = val[4:0];
			CFG_COLS: cols_reg = val[4:0];
			CFG_ITER: iter_reg = val[7:0];
			default:  eps_reg = val;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic setup(logic [4:0] r, logic [4:0] c, logic [7:0] it, logic [16:0] e);
		cfg_write(CFG_ROWS, 17'(r));
		cfg_write(CFG_COLS, 17'(c));
		cfg_write(CFG_ITER, 17'(it));
		cfg_write(CFG_EPS, e);
		gen_rows = clamp_count(r);
		gen_cols = clamp_count(c);
	endtask

	// hold the sender until every expected result is back and the block settles
	task automatic drain();
		wait (pending_cmds.size() == 0 && !s_axis_tvalid && expected_answers.size() == 0);
		repeat (100) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_val();
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: return 32'($urandom_range(0, 32'h8_0000)) - 32'h4_0000;
			5, 6: return $urandom;
			7: return 32'h7FFF_FFFF;
			8: return 32'h8000_0000;
			default: return 32'($urandom_range(0, 3));
		endcase
	endfunction

	function automatic bit in_use_written();
		for (int r = 0; r < gen_rows; r++)
			for (int c = 0; c < gen_cols; c++)
				if (!gen_written[r][c])
					return 0;
		return 1;
	endfunction

	task automatic random_reads(int n);
		int r, c;
		for (int k = 0; k < n; k++) begin
			if ($urandom_range(0, 1)) begin
				r = $urandom_range(0, 15);
				c = $urandom_range(0, 15);
				if (!gen_written[r][c]) begin
					r = $urandom_range(0, gen_rows - 1);
					c = $urandom_range(0, gen_cols - 1);
				end
				if (gen_written[r][c])
					push_cmd(FN_READ_W, 4'(r), 4'(c), 1'($urandom_range(0, 1)), $urandom);
			end else begin
				push_cmd(FN_READ_V, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
					1'($urandom_range(0, 1)), $urandom);
			end
		end
	endtask

	task automatic random_phase(int n_items);
		int start;
		logic [2:0] fn;
		start = pending_cmds.size();
		while (pending_cmds.size() - start < n_items) begin
			if ($urandom_range(0, 9) < 6) begin
				// well-formed workload: load matrix and vectors, run, read back
				if (!in_use_written() || $urandom_range(0, 1))
					for (int r = 0; r < gen_rows; r++)
						for (int c = 0; c < gen_cols; c++)
							push_cmd(FN_LOAD_W, 4'(r), 4'(c), 1'($urandom_range(0, 1)),
								rand_val());
				if ($urandom_range(0, 3) != 0)
					for (int r = 0; r < gen_rows; r++)
						push_cmd(FN_LOAD_U, 4'(r), 4'($urandom_range(0, 15)), 0, rand_val());
				if ($urandom_range(0, 1))
					for (int c = 0; c < gen_cols; c++)
						push_cmd(FN_LOAD_V, 4'($urandom_range(0, 15)), 4'(c), 1, rand_val());
				push_cmd(FN_RUN, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
					1'($urandom_range(0, 1)), $urandom);
				random_reads($urandom_range(1, 3));
			end else begin
				fn = 3'($urandom_range(0, 7));
				if (fn == FN_READ_W)
					random_reads(1);
				else if (fn != FN_RUN || in_use_written())
					push_cmd(fn, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
						1'($urandom_range(0, 1)), rand_val());
			end
		end
		drain();
	endtask

	initial begin
		foreach (w_mem[r, c]) begin
			w_mem[r][c] = 0;
			gen_written[r][c] = 0;
		end
		foreach (u_vec[i]) begin
			u_vec[i] = 0;
			v_vec[i] = 0;
		end
		sigma_q = 65536;
		rows_reg = 16;
		cols_reg = 16;
		iter_reg = 1;
		eps_reg = 1;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// directed: extremes, every command, ignored codes, zero norm
		setup(2, 2, 1, 1);
		push_cmd(FN_LOAD_W, 0, 0, 0, 32'h7FFF_FFFF);
		push_cmd(FN_LOAD_W, 0, 1, 0, 32'h8000_0000);
		push_cmd(FN_LOAD_W, 1, 0, 0, 32'h0001_0000);
		push_cmd(FN_LOAD_W, 1, 1, 1, 32'hFFFF_0000);
		push_cmd(FN_LOAD_U, 0, 15, 0, 32'h0001_0000);
		push_cmd(FN_LOAD_U, 1, 0, 0, 32'h0000_0000);
		push_cmd(FN_LOAD_V, 15, 0, 1, 32'h0000_8000);
		push_cmd(FN_LOAD_V, 0, 1, 1, 32'hFFFF_FFFF);
		push_cmd(3'd6, 15, 15, 1, 32'hFFFF_FFFF);
		push_cmd(3'd7, 0, 0, 0, 32'h0);
		push_cmd(FN_RUN, 0, 0, 0, 32'h0);
		push_cmd(FN_READ_W, 1, 1, 0, 32'h0);
		push_cmd(FN_READ_W, 0, 0, 0, 32'h0);
		push_cmd(FN_READ_V, 0, 0, 0, 32'h0);
		push_cmd(FN_READ_V, 0, 1, 1, 32'h0);
		push_cmd(FN_READ_V, 15, 15, 1, 32'h0);
		push_cmd(FN_LOAD_U, 15, 0, 0, 32'h8000_0000);
		push_cmd(FN_READ_V, 15, 0, 0, 32'h0);
		push_cmd(FN_LOAD_U, 0, 0, 0, 32'h0);
		push_cmd(FN_RUN, 0, 0, 0, 32'h0);
		push_cmd(FN_READ_W, 0, 1, 0, 32'h0);
		push_cmd(FN_READ_V, 1, 0, 0, 32'h0);
		drain();

		setup(4, 4, 2, 1);
		random_phase(100);
		setup(0, 3, 1, 0);
		random_phase(60);
		setup(31, 1, 3, 17'd65536);
		random_phase(80);
		setup(1, 1, 255, 17'h1FFFF);
		random_phase(40);
		setup(1, 16, 0, 17'd65536);
		random_phase(80);
		setup(6, 5, 3, 1);
		random_phase(120);
		setup(3, 8, 1, 100);
		random_phase(80);

		repeat (200) @(posedge clk);
		if (expected_answers.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", expected_answers.size()));
		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
